[hw/rtl/sensor_reading_compensation_core_defines.svh]
// Assertion macros shared by the compensation core.
// Both expect signals named clk and rst in the scope where they are used.
`ifndef SENSOR_READING_COMPENSATION_CORE_DEFINES_SVH
`define SENSOR_READING_COMPENSATION_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SRCOMP_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SRCOMP_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/srcomp_pkg.sv]
// ----------------------------------------------------------------------------
// srcomp_pkg
// Types, register indexes and constants of the sensor compensation core.
// ----------------------------------------------------------------------------
package srcomp_pkg;

  typedef logic [63:0] word_t;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 48;

  localparam logic [CfgIdxW-1:0] REG_TEMP    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_PRESS_A = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_PRESS_B = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_PRESS_C = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_HUM_A   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_HUM_B   = 3'd5;

  localparam logic [19:0] SKIP_RAW20 = 20'h80000;
  localparam logic [15:0] SKIP_RAW16 = 16'h8000;

  // Sign-extend the low 32 bits of a word.
  function automatic word_t sx32(input word_t x);
    return {{32{x[31]}}, x[31:0]};
  endfunction

endpackage

[hw/rtl/srcomp_in_if.sv]
// ----------------------------------------------------------------------------
// srcomp_in_if
// Raw reading channel: presence flag and three raw sensor values.
// ----------------------------------------------------------------------------
interface srcomp_in_if;
  logic        valid;
  logic        ready;
  logic        device_present;
  logic [19:0] raw_temperature;
  logic [19:0] raw_pressure;
  logic [15:0] raw_humidity;

  modport source (output valid, device_present, raw_temperature, raw_pressure,
                  raw_humidity, input ready);
  modport sink   (input valid, device_present, raw_temperature, raw_pressure,
                  raw_humidity, output ready);
endinterface

[hw/rtl/srcomp_out_if.sv]
// ----------------------------------------------------------------------------
// srcomp_out_if
// Compensated result channel.
// ----------------------------------------------------------------------------
interface srcomp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] temperature_out;
  logic        [16:0] humidity_out;
  logic        [31:0] pressure_out;

  modport source (output valid, temperature_out, humidity_out, pressure_out,
                  input ready);
  modport sink   (input valid, temperature_out, humidity_out, pressure_out,
                  output ready);
endinterface

[hw/rtl/srcomp_cfg_if.sv]
// ----------------------------------------------------------------------------
// srcomp_cfg_if
// Calibration register write channel.
// ----------------------------------------------------------------------------
interface srcomp_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [srcomp_pkg::CfgIdxW-1:0]  index;
  logic [srcomp_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/sensor_reading_compensation_core.sv]
// Sequencing: each reading runs through a shared bit-serial multiplier (one multiplier
//   bit per cycle, stopping once the remaining bits are zero, 21 products) and a
//   restoring divider.
// Throughput: one reading at a time; the next is taken once the previous result
//   is loaded into the output register, which waits while that register is full.
// Reset (rst, synchronous): calibration registers and fine temperature cleared.
// ----------------------------------------------------------------------------
// sensor_reading_compensation_core
// Integer compensation of temperature, humidity and pressure readings. A step
// sequencer feeds one shift-and-add multiplier and one radix-2 divider; the
// fine temperature is kept between readings for reuse when temperature is
// skipped.
// ----------------------------------------------------------------------------
`include "sensor_reading_compensation_core_defines.svh"

module sensor_reading_compensation_core (
  input  logic         clk,
  input  logic         rst,
  srcomp_in_if.sink    sample,
  srcomp_out_if.source result,
  srcomp_cfg_if.sink   cfg
);

  // Sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ISSUE = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_WB    = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  // Step of the divide and the last step of the program
  localparam logic [4:0] STEP_DIV  = 5'd18;
  localparam logic [4:0] LAST_STEP = 5'd21;

  // Calibration registers
  logic [47:0] tc, pa, pb, pc, ha;
  logic [23:0] hb;

  // Kept fine temperature and the working copy for this reading
  logic [31:0] ft, ftw;

  // Latched reading
  logic        dev;
  logic [19:0] rt, rp;
  logic [15:0] rh;

  // Sequencer
  logic [2:0] state;
  logic [4:0] step;

  // Scratch registers
  srcomp_pkg::word_t s0, s1, s2, s3, s4, s5;

  // Multiplier: ma shifts right, mb shifts left, macc accumulates
  srcomp_pkg::word_t ma, mb, macc;

  // Divider: dq holds the numerator shifting out and the quotient shifting in
  srcomp_pkg::word_t dq, dd, drem;
  logic [5:0]        dcnt;
  logic              dneg;
  logic              pzero;

  // Results waiting for the output register
  logic [31:0] tres, pres;
  logic [16:0] hres;

  // Output register
  logic               ovalid;
  logic signed [31:0] otemp;
  logic        [16:0] ohum;
  logic        [31:0] opress;

  // Coefficients, sign- or zero-extended to a full word
  srcomp_pkg::word_t t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  srcomp_pkg::word_t h1, h2, h3, h5, h6;

  assign t2 = 64'($signed(tc[31:16]));
  assign t3 = 64'($signed(tc[47:32]));
  assign p1 = {48'd0, pa[15:0]};
  assign p2 = 64'($signed(pa[31:16]));
  assign p3 = 64'($signed(pa[47:32]));
  assign p4 = 64'($signed(pb[15:0]));
  assign p5 = 64'($signed(pb[31:16]));
  assign p6 = 64'($signed(pb[47:32]));
  assign p7 = 64'($signed(pc[15:0]));
  assign p8 = 64'($signed(pc[31:16]));
  assign p9 = 64'($signed(pc[47:32]));
  assign h1 = {56'd0, ha[7:0]};
  assign h2 = 64'($signed(ha[23:8]));
  assign h3 = {56'd0, ha[31:24]};
  assign h5 = 64'($signed(hb[15:0]));
  assign h6 = 64'($signed(hb[23:16]));

  // Derived operands
  logic [31:0]       ta, td, hx;
  srcomp_pkg::word_t pv1, padc;

  assign ta   = {15'd0, rt[19:3]} - {15'd0, tc[15:0], 1'b0};
  assign td   = {16'd0, rt[19:4]} - {16'd0, tc[15:0]};
  assign hx   = ftw - 32'd76800;
  assign pv1  = srcomp_pkg::sx32({32'd0, ftw}) - 64'd128000;
  assign padc = 64'd1048576 - {44'd0, rp};

  // Multiplier operands for each step; a small or positive factor goes to A
  // where possible, so the serial pass ends early.
  srcomp_pkg::word_t opa, opb;

  always_comb begin
    opa = '0;
    opb = '0;
    unique case (step)
      5'd0:  begin opa = {32'd0, ta}; opb = t2; end
      5'd1:  begin opa = {32'd0, td}; opb = {32'd0, td}; end
      5'd2:  begin opa = s1; opb = t3; end
      5'd3:  begin opa = {32'd0, hx}; opb = h5; end
      5'd4:  begin opa = {32'd0, hx}; opb = h6; end
      5'd5:  begin opa = h3; opb = {32'd0, hx}; end
      5'd6:  begin opa = s3; opb = s4; end
      5'd7:  begin opa = s3; opb = h2; end
      5'd8:  begin opa = s2; opb = s3; end
      5'd9:  begin opa = s5; opb = s5; end
      5'd10: begin opa = h1; opb = s5; end
      5'd11: begin opa = pv1; opb = pv1; end
      5'd12: begin opa = s0; opb = p6; end
      5'd13: begin opa = pv1; opb = p5; end
      5'd14: begin opa = s0; opb = p3; end
      5'd15: begin opa = pv1; opb = p2; end
      5'd16: begin opa = p1; opb = 64'h0000_8000_0000_0000 + s2; end
      5'd17: begin opa = 64'd3125; opb = (padc << 31) - s1; end
      5'd19: begin opa = p9; opb = 64'($signed(s4) >>> 13); end
      5'd20: begin opa = s5; opb = 64'($signed(s4) >>> 13); end
      5'd21: begin opa = p8; opb = s4; end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  // Writeback helpers
  srcomp_pkg::word_t prod, psx;
  logic [31:0]       ftc, f5, hvv, hsub;
  logic [64:0]       dshift, ddiff;
  srcomp_pkg::word_t psum;

  assign prod   = macc;
  assign psx    = srcomp_pkg::sx32(macc);
  assign ftc    = s0[31:0] + 32'($signed(psx) >>> 14);
  assign f5     = (ftc << 2) + ftc;
  assign hsub   = 32'($signed(prod[31:0]) >>> 4);
  assign hvv    = s4[31:0] - hsub;
  assign psum   = s4 + s5 + 64'($signed(prod) >>> 19);
  assign dshift = {drem, dq[63]};
  assign ddiff  = dshift - {1'b0, dd};

  // Configuration: always ready, unknown indexes dropped
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tc <= '0; pa <= '0; pb <= '0; pc <= '0; ha <= '0; hb <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        srcomp_pkg::REG_TEMP:    tc <= cfg.data;
        srcomp_pkg::REG_PRESS_A: pa <= cfg.data;
        srcomp_pkg::REG_PRESS_B: pb <= cfg.data;
        srcomp_pkg::REG_PRESS_C: pc <= cfg.data;
        srcomp_pkg::REG_HUM_A:   ha <= cfg.data;
        srcomp_pkg::REG_HUM_B:   hb <= cfg.data[23:0];
        default: ;
      endcase
    end
  end

  assign sample.ready = (state == ST_IDLE);

  assign result.valid           = ovalid;
  assign result.temperature_out = otemp;
  assign result.humidity_out    = ohum;
  assign result.pressure_out    = opress;

  // Sequencer, multiplier and divider
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      step   <= '0;
      ft     <= '0;
      ovalid <= 1'b0;
    end else begin
      // Drop the output transaction once taken, unless a new result loads now
      if (ovalid && result.ready && state != ST_DONE) begin
        ovalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (sample.valid) begin
            dev   <= sample.device_present;
            rt    <= sample.raw_temperature;
            rp    <= sample.raw_pressure;
            rh    <= sample.raw_humidity;
            pzero <= 1'b0;
            step  <= '0;
            state <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          if (step == STEP_DIV) begin
            // Zero divisor: skip the divide, result forced later
            if (s2 == '0) begin
              pzero <= 1'b1;
              state <= ST_WB;
            end else begin
              dneg  <= s3[63] ^ s2[63];
              dq    <= s3[63] ? -s3 : s3;
              dd    <= s2[63] ? -s2 : s2;
              drem  <= '0;
              dcnt  <= '0;
              state <= ST_DIV;
            end
          end else begin
            ma    <= opa;
            mb    <= opb;
            macc  <= '0;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (ma == '0) begin
            state <= ST_WB;
          end else begin
            if (ma[0]) begin
              macc <= macc + mb;
            end
            ma <= ma >> 1;
            mb <= mb << 1;
          end
        end
        ST_DIV: begin
          if (!ddiff[64]) begin
            drem <= ddiff[63:0];
            dq   <= {dq[62:0], 1'b1};
          end else begin
            drem <= dshift[63:0];
            dq   <= {dq[62:0], 1'b0};
          end
          dcnt <= dcnt + 6'd1;
          if (dcnt == 6'd63) begin
            state <= ST_WB;
          end
        end
        ST_WB: begin
          case (step)
            5'd0:  s0 <= 64'($signed(psx) >>> 11);
            5'd1:  s1 <= 64'($signed(psx) >>> 12);
            5'd2: begin
              // Keep the stored fine temperature when temperature is skipped
              ftw  <= (rt != srcomp_pkg::SKIP_RAW20) ? ftc : ft;
              tres <= 32'($signed(f5 + 32'd128) >>> 8) - 32'd500;
            end
            5'd3:  s2 <= {32'd0, 32'($signed({2'b00, rh, 14'd0} - {ha[43:32], 20'd0}
                         - prod[31:0] + 32'd16384) >>> 15)};
            5'd4:  s3 <= 64'($signed(psx) >>> 10);
            5'd5:  s4 <= {32'd0, 32'($signed(prod[31:0]) >>> 11) + 32'd32768};
            5'd6:  s3 <= {32'd0, 32'($signed(prod[31:0]) >>> 10) + 32'd2097152};
            5'd7:  s3 <= {32'd0, 32'($signed(prod[31:0] + 32'd8192) >>> 14)};
            5'd8: begin
              s4 <= {32'd0, prod[31:0]};
              s5 <= {32'd0, 32'($signed(prod[31:0]) >>> 15)};
            end
            5'd9:  s5 <= {32'd0, 32'($signed(prod[31:0]) >>> 7)};
            5'd10: begin
              // Clamp to 0..100 %RH in Q10.22 before dropping 12 bits
              if (hvv[31]) begin
                hres <= '0;
              end else if (hvv > 32'd419430400) begin
                hres <= 17'd102400;
              end else begin
                hres <= hvv[28:12];
              end
            end
            5'd11: s0 <= prod;
            5'd12: s1 <= prod;
            5'd13: s1 <= s1 + (prod << 17) + (p4 << 35);
            5'd14: s2 <= 64'($signed(prod) >>> 8);
            5'd15: s2 <= s2 + (prod << 12);
            5'd16: s2 <= 64'($signed(prod) >>> 33);
            5'd17: s3 <= prod;
            5'd18: s4 <= dneg ? -dq : dq;
            5'd19: s5 <= prod;
            5'd20: s5 <= 64'($signed(prod) >>> 25);
            5'd21: pres <= 32'(64'($signed(psum) >>> 8) + (p7 << 4)) + 32'd6400;
            default: ;
          endcase
          if (step == LAST_STEP) begin
            state <= ST_DONE;
          end else begin
            step  <= step + 5'd1;
            state <= ST_ISSUE;
          end
        end
        ST_DONE: begin
          // Hold until the output register is free
          if (!ovalid || result.ready) begin
            ovalid <= 1'b1;
            otemp  <= (dev && rt != srcomp_pkg::SKIP_RAW20) ? $signed(tres) : '0;
            ohum   <= (dev && rh != srcomp_pkg::SKIP_RAW16) ? hres : '0;
            opress <= (dev && rp != srcomp_pkg::SKIP_RAW20) ?
                      (pzero ? 32'd6400 : pres) : '0;
            if (dev && rt != srcomp_pkg::SKIP_RAW20) begin
              ft <= ftw;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `SRCOMP_ASSERT_NXT(a_accept_starts, sample.valid && sample.ready, state == ST_ISSUE && step == 5'd0, "accepted reading did not start the program")
  `SRCOMP_ASSERT_IMP(a_step_range, state != ST_IDLE, step <= LAST_STEP, "step beyond end of program")
  `SRCOMP_ASSERT_NXT(a_mul_ends, state == ST_MUL && ma == '0, state == ST_WB, "multiplier did not hand over to writeback")
  `SRCOMP_ASSERT_IMP(a_div_step, state == ST_DIV, step == STEP_DIV, "divider running outside its step")

endmodule
